>>> rtl/core/asfpae_pkg.sv
// Package for the ASF packet audio payload extractor.
// Holds the parse phase codes, error codes, register indexes and the result type.
// No dependencies.
package asfpae_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h82;

    localparam logic [3:0] PH_SYNC    = 4'd0;
    localparam logic [3:0] PH_EC      = 4'd1;
    localparam logic [3:0] PH_FLAGS   = 4'd2;
    localparam logic [3:0] PH_PROP    = 4'd3;
    localparam logic [3:0] PH_LEN     = 4'd4;
    localparam logic [3:0] PH_SEQ     = 4'd5;
    localparam logic [3:0] PH_PAD     = 4'd6;
    localparam logic [3:0] PH_TIME    = 4'd7;
    localparam logic [3:0] PH_MULT    = 4'd8;
    localparam logic [3:0] PH_SID     = 4'd9;
    localparam logic [3:0] PH_HSKIP   = 4'd10;
    localparam logic [3:0] PH_REPLEN  = 4'd11;
    localparam logic [3:0] PH_REPDATA = 4'd12;
    localparam logic [3:0] PH_PLEN    = 4'd13;
    localparam logic [3:0] PH_CSKIP   = 4'd14;
    localparam logic [3:0] PH_DATA    = 4'd15;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SYNC     = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_HEADER   = 3'd3;
    localparam logic [2:0] ERR_LEN_TYPE = 3'd4;

    localparam logic REG_PACKET_SIZE = 1'b0;
    localparam logic REG_STREAM_ID   = 1'b1;

    localparam logic [1:0] LEN_TYPE_WORD = 2'd2;

    typedef struct packed {
        logic        has_result;
        logic [7:0]  audio_byte;
        logic        audio_valid;
        logic        packet_end;
        logic [15:0] audio_count;
        logic [2:0]  error_code;
    } result_t;

    // A two-bit width code stands for 0, 1, 2 or 4 bytes.
    function automatic logic [2:0] width_of(input logic [1:0] code);
        logic [2:0] w;
        w = (code == 2'd3) ? 3'd4 : {1'b0, code};
        return w;
    endfunction

endpackage

>>> rtl/core/asfpae_parser.sv
// Byte-serial ASF data packet parser: holds the parse state and computes one
// result per accepted byte in a single combinational pass.
// Depends on asfpae_pkg.
module asfpae_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         packet_size,
    input  logic [6:0]          audio_stream_id,
    output asfpae_pkg::result_t res
);
    import asfpae_pkg::*;

    logic [3:0]  phase_reg,  phase_next;
    logic [15:0] pbc_reg,    pbc_next;
    logic [7:0]  pflags_reg, pflags_next;
    logic [7:0]  prop_reg,   prop_next;
    logic [31:0] acc_reg,    acc_next;
    logic [2:0]  fbl_reg,    fbl_next;
    logic [15:0] pad_reg,    pad_next;
    logic [5:0]  pl_left_reg, pl_left_next;
    logic [1:0]  kind_reg,   kind_next;
    logic [6:0]  stream_reg, stream_next;
    logic [31:0] skip_reg,   skip_next;
    logic [15:0] plen_reg,   plen_next;
    logic [15:0] seen_reg,   seen_next;
    logic [2:0]  err_reg,    err_next;
    logic        comp_reg,   comp_next;

    logic [3:0]  ph;
    logic        go;
    logic        cmp;
    logic [2:0]  n;
    logic [1:0]  k;
    logic [7:0]  emit;
    logic        valid;
    logic        pend;
    logic [32:0] pad_sum;
    logic [16:0] used;

    function automatic logic [2:0] field_width(input logic [3:0] p, input logic [7:0] pf,
                                               input logic [7:0] pr);
        logic [2:0] w;
        case (p)
            PH_LEN:    w = width_of(pf[6:5]);
            PH_SEQ:    w = width_of(pf[2:1]);
            PH_PAD:    w = width_of(pf[4:3]);
            PH_REPLEN: w = width_of(pr[1:0]);
            PH_PLEN:   w = 3'd2;
            default:   w = 3'd0;
        endcase
        return w;
    endfunction

    always_comb
    begin
        phase_next   = phase_reg;
        pbc_next     = pbc_reg;
        pflags_next  = pflags_reg;
        prop_next    = prop_reg;
        acc_next     = acc_reg;
        fbl_next     = fbl_reg;
        pad_next     = pad_reg;
        pl_left_next = pl_left_reg;
        kind_next    = kind_reg;
        stream_next  = stream_reg;
        skip_next    = skip_reg;
        plen_next    = plen_reg;
        seen_next    = seen_reg;
        err_next     = err_reg;
        comp_next    = comp_reg;
        ph           = phase_reg;
        go           = 1'b0;
        cmp          = 1'b0;
        n            = 3'd0;
        k            = 2'd0;
        emit         = 8'd0;
        valid        = 1'b0;
        pend         = 1'b0;
        pad_sum      = 33'd0;
        used         = 17'd0;

        if (err_reg == ERR_NONE)
        begin
            if (pbc_reg != 16'hFFFF)
            begin
                pbc_next = pbc_reg + 16'd1;
            end

            // Work of the byte itself.
            case (phase_reg)
                PH_SYNC:
                begin
                    if (data_byte != SYNC_BYTE)
                    begin
                        err_next = ERR_SYNC;
                    end
                    else
                    begin
                        pbc_next   = 16'd1;
                        seen_next  = 16'd0;
                        pad_next   = 16'd0;
                        skip_next  = 32'd2;
                        phase_next = PH_EC;
                    end
                end
                PH_EC:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        phase_next = PH_FLAGS;
                    end
                end
                PH_FLAGS:
                begin
                    pflags_next = data_byte;
                    phase_next  = PH_PROP;
                end
                PH_PROP:
                begin
                    prop_next = data_byte;
                    ph        = PH_LEN;
                    go        = 1'b1;
                end
                PH_LEN, PH_SEQ, PH_PAD, PH_REPLEN, PH_PLEN:
                begin
                    n        = field_width(phase_reg, pflags_reg, prop_reg);
                    k        = 2'(n - fbl_reg);
                    acc_next = acc_reg | ({24'd0, data_byte} << {k, 3'b000});
                    fbl_next = fbl_reg - 3'd1;
                    if (fbl_next == 3'd0)
                    begin
                        cmp = 1'b1;
                        ph  = phase_reg;
                    end
                end
                PH_TIME:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        ph = PH_MULT;
                        go = 1'b1;
                    end
                end
                PH_MULT:
                begin
                    pl_left_next = data_byte[5:0];
                    kind_next    = data_byte[7:6];
                    if (pbc_next > packet_size)
                    begin
                        err_next = ERR_HEADER;
                    end
                    ph = PH_SID;
                    go = 1'b1;
                end
                PH_SID:
                begin
                    stream_next  = data_byte[6:0];
                    pl_left_next = pl_left_reg - 6'd1;
                    ph           = PH_HSKIP;
                    go           = 1'b1;
                end
                PH_HSKIP, PH_REPDATA, PH_CSKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        go = 1'b1;
                        case (phase_reg)
                            PH_HSKIP:   ph = PH_REPLEN;
                            PH_REPDATA: ph = PH_PLEN;
                            default:    ph = PH_DATA;
                        endcase
                    end
                end
                default:
                begin
                    if (plen_reg != 16'd0)
                    begin
                        if (stream_reg == audio_stream_id)
                        begin
                            valid = 1'b1;
                            emit  = data_byte;
                            if (seen_reg != 16'hFFFF)
                            begin
                                seen_next = seen_reg + 16'd1;
                            end
                        end
                        plen_next = plen_reg - 16'd1;
                        if (plen_next == 16'd0)
                        begin
                            ph = PH_DATA;
                            go = 1'b1;
                        end
                    end
                end
            endcase

            // Steps that take no byte, in the order the packet layout visits them.
            if (go && err_next == ERR_NONE && ph == PH_LEN)
            begin
                acc_next = 32'd0;
                n = field_width(PH_LEN, pflags_next, prop_next);
                if (n != 3'd0)
                begin
                    fbl_next = n;
                    phase_next = PH_LEN;
                    go = 1'b0;
                end
                else
                begin
                    cmp = 1'b1;
                end
            end
            if (cmp && err_next == ERR_NONE && ph == PH_LEN)
            begin
                cmp = 1'b0;
                go  = 1'b1;
                if (pflags_next[6:5] != 2'd0)
                begin
                    if (acc_next > {16'd0, packet_size})
                    begin
                        err_next = ERR_LENGTH;
                    end
                    else
                    begin
                        pad_next = packet_size - acc_next[15:0];
                    end
                end
                else
                begin
                    pad_next = 16'd0;
                end
                ph = PH_SEQ;
            end

            if (go && err_next == ERR_NONE && ph == PH_SEQ)
            begin
                acc_next = 32'd0;
                n = field_width(PH_SEQ, pflags_next, prop_next);
                if (n != 3'd0)
                begin
                    fbl_next = n;
                    phase_next = PH_SEQ;
                    go = 1'b0;
                end
                else
                begin
                    cmp = 1'b1;
                end
            end
            if (cmp && err_next == ERR_NONE && ph == PH_SEQ)
            begin
                cmp = 1'b0;
                go  = 1'b1;
                ph  = PH_PAD;
            end

            if (go && err_next == ERR_NONE && ph == PH_PAD)
            begin
                acc_next = 32'd0;
                n = field_width(PH_PAD, pflags_next, prop_next);
                if (n != 3'd0)
                begin
                    fbl_next = n;
                    phase_next = PH_PAD;
                    go = 1'b0;
                end
                else
                begin
                    cmp = 1'b1;
                end
            end
            if (cmp && err_next == ERR_NONE && ph == PH_PAD)
            begin
                cmp = 1'b0;
                go  = 1'b1;
                pad_sum = {17'd0, pad_next} + {1'b0, acc_next};
                pad_next = (pad_sum > 33'h0FFFF) ? 16'hFFFF : pad_sum[15:0];
                ph = PH_TIME;
            end

            if (go && err_next == ERR_NONE && ph == PH_TIME)
            begin
                acc_next   = 32'd0;
                skip_next  = 32'd6;
                phase_next = PH_TIME;
                go         = 1'b0;
            end

            if (go && err_next == ERR_NONE && ph == PH_MULT)
            begin
                acc_next = 32'd0;
                if (pflags_next[0])
                begin
                    phase_next = PH_MULT;
                    go = 1'b0;
                end
                else
                begin
                    pl_left_next = 6'd1;
                    kind_next    = LEN_TYPE_WORD;
                    if (pbc_next > packet_size)
                    begin
                        err_next = ERR_HEADER;
                    end
                    ph = PH_SID;
                end
            end

            if (go && err_next == ERR_NONE && ph == PH_SID)
            begin
                acc_next = 32'd0;
                go = 1'b0;
                if (pl_left_next != 6'd0)
                begin
                    phase_next = PH_SID;
                end
                else
                begin
                    plen_next  = 16'd0;
                    phase_next = PH_DATA;
                end
            end

            if (go && err_next == ERR_NONE && ph == PH_HSKIP)
            begin
                acc_next  = 32'd0;
                skip_next = {29'd0, width_of(prop_next[5:4])} + {29'd0, width_of(prop_next[3:2])};
                if (skip_next != 32'd0)
                begin
                    phase_next = PH_HSKIP;
                    go = 1'b0;
                end
                else
                begin
                    ph = PH_REPLEN;
                end
            end

            if (go && err_next == ERR_NONE && ph == PH_REPLEN)
            begin
                acc_next = 32'd0;
                n = field_width(PH_REPLEN, pflags_next, prop_next);
                if (n != 3'd0)
                begin
                    fbl_next = n;
                    phase_next = PH_REPLEN;
                    go = 1'b0;
                end
                else
                begin
                    cmp = 1'b1;
                end
            end
            if (cmp && err_next == ERR_NONE && ph == PH_REPLEN)
            begin
                cmp = 1'b0;
                go  = 1'b1;
                skip_next = acc_next;
                comp_next = (acc_next == 32'd1);
                ph = PH_REPDATA;
            end

            if (go && err_next == ERR_NONE && ph == PH_REPDATA)
            begin
                acc_next = 32'd0;
                if (skip_next != 32'd0)
                begin
                    phase_next = PH_REPDATA;
                    go = 1'b0;
                end
                else
                begin
                    ph = PH_PLEN;
                end
            end

            if (go && err_next == ERR_NONE && ph == PH_PLEN)
            begin
                acc_next = 32'd0;
                if (pflags_next[0])
                begin
                    go = 1'b0;
                    if (kind_next != LEN_TYPE_WORD)
                    begin
                        err_next = ERR_LEN_TYPE;
                    end
                    else
                    begin
                        fbl_next   = 3'd2;
                        phase_next = PH_PLEN;
                    end
                end
                else
                begin
                    used = {1'b0, pbc_next} + {1'b0, pad_next};
                    plen_next = ({1'b0, packet_size} > used) ?
                                (packet_size - used[15:0]) : 16'd0;
                    ph = PH_CSKIP;
                end
            end
            if (cmp && err_next == ERR_NONE && ph == PH_PLEN)
            begin
                cmp = 1'b0;
                go  = 1'b1;
                plen_next = acc_next[15:0];
                ph = PH_CSKIP;
            end

            if (go && err_next == ERR_NONE && ph == PH_CSKIP)
            begin
                acc_next = 32'd0;
                if (comp_next)
                begin
                    skip_next  = 32'd1;
                    phase_next = PH_CSKIP;
                    go = 1'b0;
                end
                else
                begin
                    ph = PH_DATA;
                end
            end

            if (go && err_next == ERR_NONE && ph == PH_DATA)
            begin
                acc_next = 32'd0;
                if (plen_next == 16'd0 && pl_left_next != 6'd0)
                begin
                    ph = PH_SID;
                end
                else
                begin
                    phase_next = PH_DATA;
                    go = 1'b0;
                end
            end

            // The next payload header after a finished payload.
            if (go && err_next == ERR_NONE && ph == PH_SID)
            begin
                acc_next   = 32'd0;
                phase_next = PH_SID;
                go         = 1'b0;
            end

            if (err_next == ERR_NONE && phase_next >= PH_SID && pbc_next >= packet_size)
            begin
                pend       = 1'b1;
                phase_next = PH_SYNC;
            end
        end
    end

    always_comb
    begin
        res.has_result  = (err_reg == ERR_NONE) && (valid || pend || err_next != ERR_NONE);
        res.audio_byte  = emit;
        res.audio_valid = valid;
        res.packet_end  = pend;
        res.audio_count = seen_next;
        res.error_code  = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC;
            pbc_reg     <= '0;
            pflags_reg  <= '0;
            prop_reg    <= '0;
            acc_reg     <= '0;
            fbl_reg     <= '0;
            pad_reg     <= '0;
            pl_left_reg <= '0;
            kind_reg    <= '0;
            stream_reg  <= '0;
            skip_reg    <= '0;
            plen_reg    <= '0;
            seen_reg    <= '0;
            err_reg     <= ERR_NONE;
            comp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pbc_reg     <= pbc_next;
            pflags_reg  <= pflags_next;
            prop_reg    <= prop_next;
            acc_reg     <= acc_next;
            fbl_reg     <= fbl_next;
            pad_reg     <= pad_next;
            pl_left_reg <= pl_left_next;
            kind_reg    <= kind_next;
            stream_reg  <= stream_next;
            skip_reg    <= skip_next;
            plen_reg    <= plen_next;
            seen_reg    <= seen_next;
            err_reg     <= err_next;
            comp_reg    <= comp_next;
        end
    end

    // An error, once latched, never changes until reset.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE |=> err_reg == $past(err_reg))
        else $error("latched error changed");

    // No result is produced after an error has been latched.
    a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE |-> !res.has_result)
        else $error("result after latched error");

    // A multi-byte field phase always has bytes left to collect.
    a_field_left: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == ERR_NONE && (phase_reg == PH_LEN || phase_reg == PH_SEQ ||
         phase_reg == PH_PAD || phase_reg == PH_REPLEN || phase_reg == PH_PLEN))
        |-> (fbl_reg != 3'd0 && fbl_reg <= 3'd4))
        else $error("field phase without bytes left");

endmodule

>>> rtl/core/asf_packet_audio_payload_extractor_unit.sv
// Top level of the ASF packet audio payload extractor.
// Holds the configuration registers and the output register around the parser.
// Depends on asfpae_pkg and asfpae_parser.
//
// Usage: raw bytes of the ASF data object enter on the s_ stream, one byte per
// transaction. A result leaves on the m_ stream for a byte that carries an audio
// payload byte of the selected stream, ends a packet, or raises an error; other
// bytes give no result. m_tlast marks the last byte of a packet.
// Each result is on m_tvalid in the cycle after its byte is taken. Throughput
// is one byte per cycle unless the receiver stalls, set by the single-pass
// parser update between the parse state registers and the output register.
// s_tready stays high while the output register is empty or being emptied, so
// a new byte is taken in the same cycle a held result leaves. When the
// receiver stalls with a result held, s_tready drops until m_tready returns.
// Reset clears the parse state, the error and both configuration registers,
// and the parser waits for a sync byte. The user must write packet_size and
// audio_stream_id on the cfg_ port only while the block is idle; the block
// does not enforce it. After an error it takes and drops bytes until reset.
module asf_packet_audio_payload_extractor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] audio_byte, [23:8] audio_count
    output logic        m_tlast,
    output logic [3:0]  m_tuser,   // [0] audio_valid, [3:1] error_code
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import asfpae_pkg::*;

    logic [15:0] packet_size_reg;
    logic [6:0]  stream_id_reg;
    logic        s_accept;
    result_t     res;
    logic        out_valid_reg;
    result_t     out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_size_reg <= '0;
            stream_id_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PACKET_SIZE: packet_size_reg <= cfg_data;
                REG_STREAM_ID:   stream_id_reg   <= cfg_data[6:0];
                default:         packet_size_reg <= packet_size_reg;
            endcase
        end
    end

    asfpae_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (s_accept),
        .data_byte       (s_tdata),
        .packet_size     (packet_size_reg),
        .audio_stream_id (stream_id_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= res.has_result;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && res.has_result)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.audio_count, out_reg.audio_byte};
    assign m_tlast  = out_reg.packet_end;
    assign m_tuser  = {out_reg.error_code, out_reg.audio_valid};

    // A packet end is only reported while no error is latched.
    a_end_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> out_reg.error_code == ERR_NONE)
        else $error("packet end carries an error");

    // An audio byte never comes with an error.
    a_audio_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.audio_valid) |-> out_reg.error_code == ERR_NONE)
        else $error("audio byte carries an error");

    // A held result that is not taken keeps the input stalled.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_accept)
        else $error("byte taken while result stalled");

endmodule

>>> dv/asf_packet_audio_payload_extractor_unit_tb.sv
// Testbench for the ASF packet audio payload extractor: feeds ASF packet byte streams
// and checks every result transaction against a built-in parser model.
// Depends on asfpae_pkg and asf_packet_audio_payload_extractor_unit.
`timescale 1ns / 100ps

module asf_packet_audio_payload_extractor_unit_tb;
    import asfpae_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 115;

    typedef struct packed {
        bit [7:0]  audio_byte;
        bit        audio_valid;
        bit        packet_end;
        bit [15:0] audio_count;
        bit [2:0]  error_code;
    } extract_result_t;

    class asf_extract_scoreboard;
        bit [15:0] pkt_size;
        bit [6:0]  audio_sid;
        bit [3:0]  phase;
        bit [15:0] byte_cnt;
        bit [7:0]  flags;
        bit [7:0]  props;
        bit [31:0] acc;
        bit [2:0]  fbytes_left;
        bit [15:0] pad_cnt;
        bit [5:0]  pays_left;
        bit [1:0]  len_type;
        bit [6:0]  stream;
        bit [31:0] skip_left;
        bit [15:0] pay_left;
        bit [15:0] audio_seen;
        bit [2:0]  err;
        bit        compressed;
        extract_result_t expected_audio_results[$];
        int mismatches;

        function int unsigned code_to_bytes(bit [1:0] code);
            return (code == 2'd3) ? 4 : code;
        endfunction

        function int unsigned field_len(bit [3:0] ph);
            case (ph)
                PH_LEN:    return code_to_bytes(flags[6:5]);
                PH_SEQ:    return code_to_bytes(flags[2:1]);
                PH_PAD:    return code_to_bytes(flags[4:3]);
                PH_REPLEN: return code_to_bytes(props[1:0]);
                PH_PLEN:   return 2;
                default:   return 0;
            endcase
        endfunction

        function void raise(bit [2:0] code);
            if (err == ERR_NONE)
            begin
                err = code;
            end
        endfunction

        function bit [3:0] finish_field(bit [3:0] ph);
            bit [32:0] sum;
            case (ph)
                PH_LEN:
                begin
                    if (flags[6:5] != 2'd0)
                    begin
                        if (acc > {16'd0, pkt_size})
                        begin
                            raise(ERR_LENGTH);
                            return PH_SEQ;
                        end
                        pad_cnt = pkt_size - acc[15:0];
                    end
                    else
                    begin
                        pad_cnt = 16'd0;
                    end
                    return PH_SEQ;
                end
                PH_SEQ: return PH_PAD;
                PH_PAD:
                begin
                    sum = {17'd0, pad_cnt} + {1'b0, acc};
                    pad_cnt = (sum > 33'h0FFFF) ? 16'hFFFF : sum[15:0];
                    return PH_TIME;
                end
                PH_REPLEN:
                begin
                    skip_left = acc;
                    compressed = (acc == 32'd1);
                    return PH_REPDATA;
                end
                default:
                begin
                    pay_left = acc[15:0];
                    return PH_CSKIP;
                end
            endcase
        endfunction

        // Walks forward through every step that consumes no byte.
        function void enter_phase(bit [3:0] ph);
            int unsigned n;
            bit [16:0] used;
            while (1)
            begin
                if (err != ERR_NONE)
                begin
                    return;
                end
                phase = ph;
                acc = 32'd0;
                case (ph)
                    PH_LEN, PH_SEQ, PH_PAD, PH_REPLEN:
                    begin
                        n = field_len(ph);
                        if (n != 0)
                        begin
                            fbytes_left = n;
                            return;
                        end
                        ph = finish_field(ph);
                    end
                    PH_TIME:
                    begin
                        skip_left = 32'd6;
                        return;
                    end
                    PH_MULT:
                    begin
                        if (flags[0])
                        begin
                            return;
                        end
                        pays_left = 6'd1;
                        len_type = LEN_TYPE_WORD;
                        if (byte_cnt > pkt_size)
                        begin
                            raise(ERR_HEADER);
                        end
                        ph = PH_SID;
                    end
                    PH_SID:
                    begin
                        if (pays_left == 6'd0)
                        begin
                            pay_left = 16'd0;
                            phase = PH_DATA;
                        end
                        return;
                    end
                    PH_HSKIP:
                    begin
                        skip_left = code_to_bytes(props[5:4]) + code_to_bytes(props[3:2]);
                        if (skip_left != 32'd0)
                        begin
                            return;
                        end
                        ph = PH_REPLEN;
                    end
                    PH_REPDATA:
                    begin
                        if (skip_left != 32'd0)
                        begin
                            return;
                        end
                        ph = PH_PLEN;
                    end
                    PH_PLEN:
                    begin
                        if (flags[0])
                        begin
                            if (len_type != LEN_TYPE_WORD)
                            begin
                                raise(ERR_LEN_TYPE);
                                return;
                            end
                            fbytes_left = 3'd2;
                            return;
                        end
                        used = {1'b0, byte_cnt} + {1'b0, pad_cnt};
                        pay_left = ({1'b0, pkt_size} > used) ? pkt_size - used[15:0] : 16'd0;
                        ph = PH_CSKIP;
                    end
                    PH_CSKIP:
                    begin
                        if (compressed)
                        begin
                            skip_left = 32'd1;
                            return;
                        end
                        ph = PH_DATA;
                    end
                    default:
                    begin
                        if (pay_left == 16'd0 && pays_left != 6'd0)
                        begin
                            ph = PH_SID;
                        end
                        else
                        begin
                            return;
                        end
                    end
                endcase
            end
        endfunction

        function void note_byte(bit [7:0] b);
            extract_result_t r;
            int unsigned k;
            if (err != ERR_NONE)
            begin
                return;
            end
            r = '0;
            if (byte_cnt != 16'hFFFF)
            begin
                byte_cnt++;
            end
            case (phase)
                PH_SYNC:
                begin
                    if (b != SYNC_BYTE)
                    begin
                        raise(ERR_SYNC);
                    end
                    else
                    begin
                        byte_cnt = 16'd1;
                        audio_seen = 16'd0;
                        pad_cnt = 16'd0;
                        skip_left = 32'd2;
                        phase = PH_EC;
                    end
                end
                PH_EC:
                begin
                    skip_left--;
                    if (skip_left == 32'd0)
                    begin
                        phase = PH_FLAGS;
                    end
                end
                PH_FLAGS:
                begin
                    flags = b;
                    phase = PH_PROP;
                end
                PH_PROP:
                begin
                    props = b;
                    enter_phase(PH_LEN);
                end
                PH_LEN, PH_SEQ, PH_PAD, PH_REPLEN, PH_PLEN:
                begin
                    k = field_len(phase) - fbytes_left;
                    acc |= {24'd0, b} << (8 * (k & 3));
                    fbytes_left--;
                    if (fbytes_left == 3'd0)
                    begin
                        enter_phase(finish_field(phase));
                    end
                end
                PH_TIME:
                begin
                    skip_left--;
                    if (skip_left == 32'd0)
                    begin
                        enter_phase(PH_MULT);
                    end
                end
                PH_MULT:
                begin
                    pays_left = b[5:0];
                    len_type = b[7:6];
                    if (byte_cnt > pkt_size)
                    begin
                        raise(ERR_HEADER);
                    end
                    enter_phase(PH_SID);
                end
                PH_SID:
                begin
                    stream = b[6:0];
                    pays_left = pays_left - 6'd1;
                    enter_phase(PH_HSKIP);
                end
                PH_HSKIP:
                begin
                    skip_left--;
                    if (skip_left == 32'd0)
                    begin
                        enter_phase(PH_REPLEN);
                    end
                end
                PH_REPDATA:
                begin
                    skip_left--;
                    if (skip_left == 32'd0)
                    begin
                        enter_phase(PH_PLEN);
                    end
                end
                PH_CSKIP:
                begin
                    skip_left--;
                    if (skip_left == 32'd0)
                    begin
                        enter_phase(PH_DATA);
                    end
                end
                default:
                begin
                    if (pay_left != 16'd0)
                    begin
                        if (stream == audio_sid)
                        begin
                            r.audio_valid = 1'b1;
                            r.audio_byte = b;
                            if (audio_seen != 16'hFFFF)
                            begin
                                audio_seen++;
                            end
                        end
                        pay_left--;
                        if (pay_left == 16'd0)
                        begin
                            enter_phase(PH_DATA);
                        end
                    end
                end
            endcase
            if (err == ERR_NONE && phase >= PH_SID && byte_cnt >= pkt_size)
            begin
                r.packet_end = 1'b1;
                phase = PH_SYNC;
            end
            if (!r.audio_valid && !r.packet_end && err == ERR_NONE)
            begin
                return;
            end
            r.audio_count = audio_seen;
            r.error_code = err;
            expected_audio_results.push_back(r);
        endfunction

        function void check_result(bit [23:0] data, bit last, bit [3:0] user);
            extract_result_t want;
            extract_result_t got;
            got.audio_byte = data[7:0];
            got.audio_count = data[23:8];
            got.packet_end = last;
            got.audio_valid = user[0];
            got.error_code = user[3:1];
            if (expected_audio_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transaction: byte %02h valid %0d end %0d count %0d err %0d",
                             got.audio_byte, got.audio_valid, got.packet_end, got.audio_count,
                             got.error_code);
                end
                return;
            end
            want = expected_audio_results.pop_front();
            if (want.audio_byte != got.audio_byte || want.audio_valid != got.audio_valid ||
                want.packet_end != got.packet_end || want.audio_count != got.audio_count ||
                want.error_code != got.error_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch at %0t: expected byte %02h valid %0d end %0d count %0d err %0d",
                             $realtime, want.audio_byte, want.audio_valid, want.packet_end,
                             want.audio_count, want.error_code);
                    $display("                        got byte %02h valid %0d end %0d count %0d err %0d",
                             got.audio_byte, got.audio_valid, got.packet_end, got.audio_count,
                             got.error_code);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    asf_extract_scoreboard sb = new;
    int        send_idle;
    int        recv_stall;
    bit        hold_req;
    logic [2:0] err_kind;
    bit [31:0] field_target;
    int        idle_cycles;

    asf_packet_audio_payload_extractor_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_byte(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("asf_packet_audio_payload_extractor_unit regression: fail");
                $finish;
            end
        end
    end

    // The long hold-off is counted here so the sender keeps offering bytes meanwhile.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Picks a byte that fits the parser's current position, so most packets are well formed.
    function automatic bit [7:0] next_asf_byte();
        bit [7:0] b;
        int unsigned w;
        int unsigned k;
        int unsigned lim;
        int unsigned roll;
        b = $urandom;
        roll = $urandom_range(99);
        case (sb.phase)
            PH_SYNC:
            begin
                if (err_kind != ERR_SYNC)
                begin
                    b = SYNC_BYTE;
                end
                else if (b == SYNC_BYTE)
                begin
                    b = ~b;
                end
            end
            PH_FLAGS:
            begin
                if (err_kind == ERR_LENGTH)
                begin
                    b[6:5] = 2'd2;
                end
                if (err_kind == ERR_LEN_TYPE)
                begin
                    b[0] = 1'b1;
                end
            end
            PH_LEN, PH_PAD, PH_REPLEN, PH_PLEN:
            begin
                w = sb.field_len(sb.phase);
                k = w - sb.fbytes_left;
                if (k == 0)
                begin
                    field_target = $urandom;
                    case (sb.phase)
                        PH_LEN:
                        begin
                            lim = (w == 1) ? 255 : 65535;
                            if (sb.pkt_size < lim)
                            begin
                                lim = sb.pkt_size;
                            end
                            if (err_kind == ERR_LENGTH)
                            begin
                                field_target = sb.pkt_size + $urandom_range(100, 1);
                            end
                            else if (roll < 60)
                            begin
                                field_target = lim;
                            end
                            else
                            begin
                                field_target = $urandom_range(lim, 0);
                            end
                        end
                        PH_PAD:
                        begin
                            if (roll < 70)
                            begin
                                field_target = $urandom_range(3, 0);
                            end
                            else if (roll >= 85)
                            begin
                                field_target = 32'hFFFF_FFFF;
                            end
                        end
                        PH_REPLEN:
                        begin
                            if (roll < 60)
                            begin
                                field_target = $urandom_range(8, 0);
                            end
                            else if (roll < 80)
                            begin
                                field_target = 32'd1;
                            end
                        end
                        default:
                        begin
                            if (roll < 85)
                            begin
                                field_target = $urandom_range(24, 0);
                            end
                        end
                    endcase
                end
                b = field_target >> (8 * k);
            end
            PH_MULT:
            begin
                if (err_kind == ERR_LEN_TYPE)
                begin
                    if (b[5:0] == 6'd0)
                    begin
                        b[0] = 1'b1;
                    end
                    if (b[7:6] == LEN_TYPE_WORD)
                    begin
                        b[7:6] = 2'd3;
                    end
                end
                else
                begin
                    if (roll < 85)
                    begin
                        b[5:0] = $urandom_range(4, 1);
                    end
                    else if (roll < 95)
                    begin
                        b[5:0] = 6'd0;
                    end
                    if (b[5:0] != 6'd0)
                    begin
                        b[7:6] = LEN_TYPE_WORD;
                    end
                end
            end
            PH_SID:
            begin
                if (roll < 75)
                begin
                    b[6:0] = sb.audio_sid;
                end
            end
            default:
            begin
            end
        endcase
        return b;
    endfunction

    task automatic send_byte(input bit [7:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic set_config(input bit [15:0] size, input bit [6:0] sid);
        cfg_we <= 1'b1;
        cfg_index <= REG_PACKET_SIZE;
        cfg_data <= size;
        @(negedge clk);
        cfg_index <= REG_STREAM_ID;
        cfg_data <= {9'd0, sid};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.pkt_size = size;
        sb.audio_sid = sid;
    endtask

    // A byte may give no result, so the bench keeps waiting after the last expected result arrives.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_audio_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        bit [7:0] warmup [24];
        bit [15:0] size;
        bit [6:0] sid;
        int tries;
        warmup = '{8'h82, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                   8'h83,
                   8'h82, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h3C, 8'hC3, 8'h00, 8'hFF,
                   8'h80};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        cfg_we = 1'b0;
        cfg_index = REG_PACKET_SIZE;
        cfg_data = 16'd0;
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1'b0;
        err_kind = ERR_NONE;
        field_target = 32'd0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Headers that exactly fill the packet, with and without a multiple-payload byte.
        set_config(16'd12, 7'd0);
        foreach (warmup[i])
        begin
            send_byte(warmup[i]);
        end
        settle();

        // One packet of the largest size.
        set_config(16'hFFFF, 7'd127);
        do
            send_byte(next_asf_byte());
        while (sb.phase != PH_SYNC);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 75;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 75;
                end
                default:
                begin
                    send_idle = 36;
                    recv_stall = 36;
                end
            endcase
            size = (ph == 0) ? 16'd24 : 16'($urandom_range(96, 24));
            sid = (ph == 1) ? 7'd127 : (ph == 2) ? 7'd0 : 7'($urandom_range(127, 0));
            set_config(size, sid);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            repeat (PHASE_BYTES) send_byte(next_asf_byte());
            while (!(sb.phase == PH_SYNC || sb.phase >= PH_SID))
            begin
                send_byte(next_asf_byte());
            end
            settle();
        end

        // The error latch holds until reset, so only one error kind is provoked per run.
        while (sb.phase != PH_SYNC)
        begin
            send_byte(next_asf_byte());
        end
        settle();
        err_kind = $urandom_range(ERR_LEN_TYPE, ERR_SYNC);
        if (err_kind == ERR_HEADER)
        begin
            size = ($urandom_range(1, 0) == 0) ? 16'd0 : 16'($urandom_range(10, 1));
            set_config(size, sb.audio_sid);
        end
        tries = 0;
        while (sb.err == ERR_NONE && tries < 2000)
        begin
            send_byte(next_asf_byte());
            tries++;
        end
        repeat (12) send_byte($urandom);

        s_tvalid <= 1'b0;
        while (sb.expected_audio_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_audio_results.size() == 0)
        begin
            $display("asf_packet_audio_payload_extractor_unit regression: pass");
        end
        else
        begin
            $display("asf_packet_audio_payload_extractor_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> asf_packet_audio_payload_extractor_unit.f
rtl/core/asfpae_pkg.sv
rtl/core/asfpae_parser.sv
rtl/core/asf_packet_audio_payload_extractor_unit.sv
dv/asf_packet_audio_payload_extractor_unit_tb.sv
